>>> rtl/normal_cdf_unit_macros.svh
// Assertion helpers for the normal CDF block.
`ifndef NORMAL_CDF_UNIT_MACROS_SVH
`define NORMAL_CDF_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define NCDF_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define NCDF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ncdf_pkg.sv
`timescale 1ns / 1ps
package ncdf_pkg;
   localparam int QF = 28;
   localparam logic [31:0] A_MAX_Q28 = 32'd8 << QF;
   localparam logic [32:0] U_BIG_Q28 = 33'd16 << QF;
   localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
   localparam logic [28:0] ONE_Q28 = 29'd1 << QF;

   typedef logic [24:0] coef_type;
   localparam coef_type COEF_Q28 [6] = '{
      25'd18930895, 25'd11349991, 25'd2488538, 25'd40806, 25'd74240, 25'd11560
   };

   // Register indexes of the configuration port.
   localparam logic CSR_MEAN    = 1'b0;
   localparam logic CSR_STD_DEV = 1'b1;
endpackage

>>> rtl/ncdf_req_if.sv
`timescale 1ns / 1ps
interface ncdf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/ncdf_rsp_if.sv
`timescale 1ns / 1ps
interface ncdf_rsp_if #(parameter int PW = 17);
   logic          valid;
   logic          ready;
   logic [PW-1:0] probability;
   logic          degenerate;
   modport source (output valid, output probability, output degenerate, input ready);
   modport sink (input valid, input probability, input degenerate, output ready);
endinterface

>>> rtl/ncdf_csr_if.sv
`timescale 1ns / 1ps
interface ncdf_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/normal_cdf_unit.sv
`timescale 1ns / 1ps
// normal_cdf_unit: normal cumulative probability of a Q16.16 sample.
// Channels: req (sample, signed Q16.16), rsp (probability in Q1.OUT_FRAC_BITS,
// 1.0 = 1 << OUT_FRAC_BITS, plus a degenerate flag for a zero std_dev), and
// csr (index 0 = mean, index 1 = std_dev, always ready).
// Throughput: one transaction per cycle unless rsp stalls. From the accepting
// edge to the result showing on rsp, the chain is an input register, a
// 34-stage divider (operand register plus 33 quotient stages), a scaling
// multiply, six Horner steps, a second 34-stage divider for 1/(1+t), four
// squarings and the output register, each product followed by a register.
// The whole pipeline advances only when its last stage is empty or being
// taken, so req ready falls while a result waits untaken at the output;
// nothing is lost or repeated.
// Reset: clears all valid bits, mean to 0 and std_dev to 1.0.
// Configure only while the pipeline is empty.
`include "normal_cdf_unit_macros.svh"
module normal_cdf_unit #(
   parameter int OUT_FRAC_BITS = 16
) (
   input logic     clock,
   input logic     reset,
   ncdf_req_if.sink   req,
   ncdf_rsp_if.source rsp,
   ncdf_csr_if.sink   csr
);
   localparam int NH = 6;

   logic signed [31:0] mean_ff;
   logic [30:0]        std_ff;
   logic               advance;

   // Config registers.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         std_ff  <= 31'd65536;
      end else if (csr.valid) begin
         case (csr.index)
            ncdf_pkg::CSR_MEAN:    mean_ff <= csr.data;
            ncdf_pkg::CSR_STD_DEV: std_ff  <= csr.data[30:0];
            default: ;
         endcase
      end
   end

   // Hold everything when the output holds a result nobody takes.
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Stage A: difference and magnitude.
   logic        a_vld_ff, a_neg_ff, a_deg_ff;
   logic [32:0] a_mag_ff;
   logic signed [32:0] diff;
   assign diff = 33'(signed'(req.sample)) - 33'(mean_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= req.valid;
      end
      if (advance) begin
         a_neg_ff <= diff[32];
         a_mag_ff <= diff[32] ? 33'(-diff) : 33'(diff);
         a_deg_ff <= (std_ff == '0);
      end
   end

   // Stage B: |u| = (|d| << 28) / std_dev. A zero divisor is flagged and the
   // quotient ignored.
   logic        b_vld, b_big;
   logic [32:0] b_quo;
   logic [1:0]  b_side;
   ncdf_divider #(.SW(2)) u_udiv (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(a_vld_ff), .in_mag(a_mag_ff),
      .in_den(a_deg_ff ? 33'd1 : {2'b00, std_ff}),
      .in_side({a_neg_ff, a_deg_ff}),
      .out_valid(b_vld), .out_big(b_big), .out_quo(b_quo), .out_side(b_side)
   );

   // Stage C: a = u / sqrt2, clamped at 8.
   logic        c_vld_ff, c_neg_ff, c_deg_ff;
   logic [31:0] c_a_ff;
   logic [62:0] c_prod;
   logic [32:0] c_scaled;
   assign c_prod   = 63'(b_quo) * 63'(ncdf_pkg::INV_SQRT2_Q30);
   assign c_scaled = c_prod[62:30];
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= b_vld;
      end
      if (advance) begin
         c_neg_ff <= b_side[1];
         c_deg_ff <= b_side[0];
         if (b_big || {1'b0, b_quo} >= {1'b0, ncdf_pkg::U_BIG_Q28} ||
             c_scaled > 33'(ncdf_pkg::A_MAX_Q28)) begin
            c_a_ff <= ncdf_pkg::A_MAX_Q28;
         end else begin
            c_a_ff <= c_scaled[31:0];
         end
      end
   end

   // Stages H: Horner, one product per stage. h0 = c6, then h = c_k + a*h.
   // With a <= 8 every partial sum, and 1 + t, stays below 2^33.
   logic        h_vld_ff [NH+1];
   logic        h_neg_ff [NH+1];
   logic        h_deg_ff [NH+1];
   logic [31:0] h_a_ff   [NH+1];
   logic [32:0] h_h_ff   [NH+1];
   always_comb begin
      h_vld_ff[0] = c_vld_ff;
      h_neg_ff[0] = c_neg_ff;
      h_deg_ff[0] = c_deg_ff;
      h_a_ff[0]   = c_a_ff;
      h_h_ff[0]   = 33'(ncdf_pkg::COEF_Q28[5]);
   end
   for (genvar k = 0; k < NH; k++) begin : g_horner
      logic [64:0] prod;
      logic [32:0] sum;
      assign prod = 65'(h_a_ff[k]) * 65'(h_h_ff[k]);
      // last step adds the leading 1 instead of a coefficient
      assign sum = (k == NH - 1) ? 33'(prod[64:28]) + 33'(ncdf_pkg::ONE_Q28)
                 : 33'(prod[64:28]) + 33'(ncdf_pkg::COEF_Q28[(k < NH-1) ? NH-2-k : 0]);
      always_ff @(posedge clock) begin
         if (reset) begin
            h_vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            h_vld_ff[k+1] <= h_vld_ff[k];
         end
         if (advance) begin
            h_neg_ff[k+1] <= h_neg_ff[k];
            h_deg_ff[k+1] <= h_deg_ff[k];
            h_a_ff[k+1]   <= h_a_ff[k];
            h_h_ff[k+1]   <= sum;
         end
      end
   end

   // s stays below 2^33 (a <= 8), so carry its full width into the reciprocal
   // divider: r = 2^59 / s. Reuse a second divider: (2^31 << 28) / s.
   logic [32:0] s_full;
   assign s_full = h_h_ff[NH];

   logic        r_vld, r_big;
   logic [32:0] r_quo;
   logic [1:0]  r_side;
   ncdf_divider #(.SW(2)) u_rdiv (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(h_vld_ff[NH]), .in_mag(33'd1 << 31), .in_den(s_full),
      .in_side({h_neg_ff[NH], h_deg_ff[NH]}),
      .out_valid(r_vld), .out_big(r_big), .out_quo(r_quo), .out_side(r_side)
   );

   // Stages Q: four squarings in Q31.
   logic        q_vld_ff [5];
   logic        q_neg_ff [5];
   logic        q_deg_ff [5];
   logic [31:0] q_r_ff   [5];
   always_comb begin
      q_vld_ff[0] = r_vld;
      q_neg_ff[0] = r_side[1];
      q_deg_ff[0] = r_side[0];
      q_r_ff[0]   = r_big ? 32'h8000_0000 : r_quo[31:0];
   end
   for (genvar j = 0; j < 4; j++) begin : g_square
      logic [63:0] sq;
      assign sq = 64'(q_r_ff[j]) * 64'(q_r_ff[j]);
      always_ff @(posedge clock) begin
         if (reset) begin
            q_vld_ff[j+1] <= 1'b0;
         end else if (advance) begin
            q_vld_ff[j+1] <= q_vld_ff[j];
         end
         if (advance) begin
            q_neg_ff[j+1] <= q_neg_ff[j];
            q_deg_ff[j+1] <= q_deg_ff[j];
            q_r_ff[j+1]   <= sq[62:31];
         end
      end
   end

   // Output stage: fold the sign, round half up, drop degenerate items to 0.
   logic [32:0] p_q32;
   logic [32:0] p_rnd;
   logic        o_vld_ff, o_deg_ff;
   logic [OUT_FRAC_BITS:0] o_prob_ff;
   assign p_q32 = q_neg_ff[4] ? {1'b0, q_r_ff[4]} : (33'd1 << 32) - {1'b0, q_r_ff[4]};
   assign p_rnd = p_q32 + (33'd1 << (31 - OUT_FRAC_BITS));
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (advance) begin
         o_vld_ff <= q_vld_ff[4];
      end
      if (advance) begin
         o_deg_ff  <= q_deg_ff[4];
         o_prob_ff <= q_deg_ff[4] ? '0 : p_rnd[32 -: OUT_FRAC_BITS + 1];
      end
   end

   assign rsp.valid       = o_vld_ff;
   assign rsp.degenerate  = o_deg_ff;
   assign rsp.probability = o_prob_ff;

   `NCDF_ASSERT_IMPL(a_deg_zero, clock, reset, rsp.valid && rsp.degenerate,
      rsp.probability == '0, "degenerate result carries a nonzero probability")
   `NCDF_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.probability), "stalled result changed")
   `NCDF_ASSERT_IMPL(a_range, clock, reset, rsp.valid,
      rsp.probability <= ((OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS),
      "probability above one")
endmodule

>>> rtl/ncdf_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: quotient = (mag << 28) / den, one quotient bit
// per stage for the 33 low quotient bits; higher bits only saturate.
// The remainder starts with the numerator bits above the quotient window.
// Each stage carries a sideband word through unchanged.
module ncdf_divider #(
   parameter int SW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [32:0]   in_mag,
   input  logic [32:0]   in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic          out_big,
   output logic [32:0]   out_quo,
   output logic [SW-1:0] out_side
);
   localparam int NB = 33;
   localparam int NUMW = 61;

   logic            vld_ff  [NB+1];
   logic [NUMW-1:0] rem_ff  [NB+1];
   logic [32:0]     den_ff  [NB+1];
   logic [NB-1:0]   quo_ff  [NB+1];
   logic [32:0]     mag_ff  [NB+1];
   logic            big_ff  [NB+1];
   logic [SW-1:0]   side_ff [NB+1];

   // Stage 0 takes the operands; quotient >= 2^33 means the magnitude is at
   // least den * 32, which saturates a anyway.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0]  <= NUMW'(in_mag >> 5);
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         mag_ff[0]  <= in_mag;
         big_ff[0]  <= ({28'd0, in_mag} >= ({28'd0, in_den} << 5));
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < NB; i++) begin : g_stage
      localparam int BIT = NB - 1 - i;
      logic [NUMW-1:0] trial;
      logic            numbit;
      always_comb begin
         // numerator is mag << 28; bit BIT of it
         numbit = (BIT >= 28) ? mag_ff[i][(BIT >= 28) ? BIT - 28 : 0] : 1'b0;
         trial  = {rem_ff[i][NUMW-2:0], numbit};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (advance) begin
            if (trial >= {28'd0, den_ff[i]}) begin
               rem_ff[i+1] <= trial - {28'd0, den_ff[i]};
               quo_ff[i+1] <= {quo_ff[i][NB-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= trial;
               quo_ff[i+1] <= {quo_ff[i][NB-2:0], 1'b0};
            end
            den_ff[i+1]  <= den_ff[i];
            mag_ff[i+1]  <= mag_ff[i];
            big_ff[i+1]  <= big_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[NB];
   assign out_big   = big_ff[NB];
   assign out_quo   = quo_ff[NB];
   assign out_side  = side_ff[NB];
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   localparam int OFB = 16;
   localparam int PW = OFB + 1;
   localparam int LATENCY = 81;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1200;
   localparam logic [63:0] INV_SQRT2 = 64'd759250125;

   // Coefficients c1..c6 of the erf tail approximation, rounded into Q28
   localparam logic [63:0] CDF_COEF [6] = '{
      64'd18930895, 64'd11349991, 64'd2488538, 64'd40806, 64'd74240, 64'd11560
   };

   typedef struct packed {
      logic [PW-1:0] probability;
      logic          degenerate;
   } cdf_result_type;

   // One row of the directed table: chk_known selects a typed-in answer
   typedef struct {
      logic [31:0]    sample;
      logic           chk_known;
      cdf_result_type known;
   } cdf_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ncdf_req_if req_ch ();
   ncdf_rsp_if #(.PW(PW)) rsp_ch ();
   ncdf_csr_if csr_ch ();

   normal_cdf_unit #(.OUT_FRAC_BITS(OFB)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   always #10 clock = ~clock;

   // Mirror of the block's registers
   logic signed [31:0] mean_q;
   logic [30:0] std_dev_q;

   cdf_result_type pending_cdf[$];
   int error_count = 0;
   int accepted_samples = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit quiet_phase = 1'b0;

   // Erf tail (1 + t)^-16 in Q31 for a clamped Q28 argument
   function automatic logic [63:0] erf_tail(input logic [63:0] a);
      logic [63:0] h, s, r;
      h = CDF_COEF[5];
      for (int k = 4; k >= 0; k--)
         h = CDF_COEF[k] + ((a * h) >> ncdf_pkg::QF);
      s = (64'd1 << ncdf_pkg::QF) + ((a * h) >> ncdf_pkg::QF);
      r = (64'd1 << 59) / s;
      for (int k = 0; k < 4; k++)
         r = (r * r) >> 31;
      return r;
   endfunction

   function automatic cdf_result_type normal_cdf(input logic signed [31:0] x);
      cdf_result_type res;
      logic signed [63:0] d;
      logic [63:0] mag, uq, a, q, p;
      bit neg;
      res = '0;
      if (std_dev_q == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      d = 64'(x) - 64'(mean_q);
      neg = d < 0;
      mag = neg ? 64'(-d) : 64'(d);
      uq = (mag << ncdf_pkg::QF) / 64'(std_dev_q);
      if (uq >= (64'd16 << ncdf_pkg::QF)) begin
         a = 64'd8 << ncdf_pkg::QF;
      end else begin
         a = (uq * INV_SQRT2) >> 30;
         if (a > (64'd8 << ncdf_pkg::QF)) a = 64'd8 << ncdf_pkg::QF;
      end
      q = erf_tail(a);
      p = neg ? q : ((64'd1 << 32) - q);
      res.probability = PW'((p + (64'd1 << (31 - OFB))) >> (32 - OFB));
      return res;
   endfunction

   // Sample outputs at the rising edge; compare against the oldest expectation
   always @(posedge clock) begin
      cdf_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_cdf.size() == 0) begin
            $error("result with nothing expected: probability %0d", rsp_ch.probability);
            error_count++;
         end else begin
            exp_r = pending_cdf.pop_front();
            if (rsp_ch.probability !== exp_r.probability) begin
               $error("probability expected %0d actual %0d", exp_r.probability,
                      rsp_ch.probability);
               error_count++;
            end
            if (rsp_ch.degenerate !== exp_r.degenerate) begin
               $error("degenerate expected %0d actual %0d", exp_r.degenerate,
                      rsp_ch.degenerate);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no transaction moves anywhere
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: random stalls, none in the quiet phase, all during a hold-off
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (hold_rsp)
         rsp_ch.ready <= 1'b0;
      else if (quiet_phase)
         rsp_ch.ready <= 1'b1;
      else
         rsp_ch.ready <= ($urandom_range(99) >= 11);
   end

   // Hold off the receiver for a long stretch, counted here, early in a random
   // phase so the sender keeps offering until the pipeline fills
   initial begin
      wait (accepted_samples >= 180);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(negedge clock);
      hold_rsp = 1'b0;
   end

   // Write one register; hold until the transaction is taken
   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == ncdf_pkg::CSR_MEAN) mean_q = value;
      else std_dev_q = value[30:0];
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one sample with random gaps; advance once accepted
   task automatic send_sample(input logic [31:0] x, input bit gaps);
      if (gaps && !quiet_phase)
         while ($urandom_range(99) < 11) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      req_ch.valid <= 1'b1;
      req_ch.sample <= x;
      do @(posedge clock); while (!req_ch.ready);
      pending_cdf.push_back(normal_cdf(x));
      accepted_samples++;
      @(negedge clock);
   endtask

   // Pause the sender until every expected result is back, then let the pipe drain
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_cdf.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_sample(input int mode);
      case (mode)
         0: return $urandom();
         1: return mean_q + $signed($urandom_range(8 * 65536)) - 4 * 65536;
         default: return mean_q + $signed(32'($urandom_range(64)) - 32);
      endcase
   endfunction

   initial begin
      cdf_row_type rows[$];
      cdf_row_type row;
      logic [31:0] means[6];
      logic [31:0] sds[6];
      int per_phase;
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = ncdf_pkg::CSR_MEAN;
      csr_ch.data = '0;
      mean_q = 0;
      std_dev_q = 31'd65536;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at reset settings: zero u, extremes, tail saturation
      row = '{32'h0000_0000, 1'b1, '{17'd32768, 1'b0}}; rows.push_back(row);
      row = '{32'h7FFF_FFFF, 1'b1, '{17'd65536, 1'b0}}; rows.push_back(row);
      row = '{32'h8000_0000, 1'b1, '{17'd0, 1'b0}};     rows.push_back(row);
      row = '{32'h0010_0000, 1'b1, '{17'd65536, 1'b0}}; rows.push_back(row);
      row = '{32'hFFF0_0000, 1'b1, '{17'd0, 1'b0}};     rows.push_back(row);
      row = '{32'h0001_0000, 1'b0, '0}; rows.push_back(row);
      row = '{32'hFFFF_0000, 1'b0, '0}; rows.push_back(row);
      row = '{32'h0000_0001, 1'b0, '0}; rows.push_back(row);
      row = '{32'hFFFF_FFFF, 1'b0, '0}; rows.push_back(row);
      row = '{32'h0002_8000, 1'b0, '0}; rows.push_back(row);
      row = '{32'h0005_A000, 1'b0, '0}; rows.push_back(row);
      row = '{32'hAAAA_5555, 1'b0, '0}; rows.push_back(row);
      row = '{32'h5555_AAAA, 1'b0, '0}; rows.push_back(row);
      foreach (rows[i]) begin
         send_sample(rows[i].sample, 1'b0);
         // Replace the predicted entry with the typed-in answer where one is given
         if (rows[i].chk_known)
            pending_cdf[pending_cdf.size() - 1] = rows[i].known;
      end
      drain();

      // Zero std_dev: every sample degenerate; write upper bits to check masking
      write_csr(ncdf_pkg::CSR_STD_DEV, 32'h8000_0000);
      send_sample(32'h0000_0000, 1'b0);
      pending_cdf[pending_cdf.size() - 1] = '{17'd0, 1'b1};
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      drain();

      // Random phases across mean and std_dev settings, extremes included
      means = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 32'hFFF8_8000, 32'h0};
      sds = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0};
      per_phase = N_RANDOM / 8;
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(ncdf_pkg::CSR_MEAN, ph < 5 ? means[ph] : $urandom());
         if (ph < 4) write_csr(ncdf_pkg::CSR_STD_DEV, sds[ph]);
         else write_csr(ncdf_pkg::CSR_STD_DEV, ph == 4 ? 32'(1 << $urandom_range(30))
                                             : 32'($urandom_range(32'h0010_0000, 1)));
         quiet_phase = (ph == 2);
         for (int n = 0; n < per_phase; n++)
            send_sample(rand_sample($urandom_range(2)), 1'b1);
         quiet_phase = 1'b0;
         drain();
      end

      $display("Covered %0d samples, %0d results, mean/std_dev extremes and zero std_dev.",
               accepted_samples, results_seen);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl
rtl/ncdf_pkg.sv
rtl/ncdf_req_if.sv
rtl/ncdf_rsp_if.sv
rtl/ncdf_csr_if.sv
rtl/ncdf_divider.sv
rtl/normal_cdf_unit.sv
tb/tb_top.sv
